// File: src/cfse_pkg.sv
// ----------------------------------------------------------------------------
// cfse_pkg
// Shared types and constants for the clipped frame store fill engine.
// ----------------------------------------------------------------------------
package cfse_pkg;

  // Widths of the command fields and of one pixel.
  localparam int unsigned FieldW  = 16;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  // Command codes.
  typedef enum logic [OpW-1:0] {
    OP_FILL  = 2'd0,
    OP_BLIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_W = 3'd0,
    CFG_SCREEN_H = 3'd1,
    CFG_CLIP_L   = 3'd2,
    CFG_CLIP_T   = 3'd3,
    CFG_CLIP_R   = 3'd4,
    CFG_CLIP_B   = 3'd5
  } cfg_reg_e;

endpackage

// File: src/cfse_ram.sv
// ----------------------------------------------------------------------------
// cfse_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One access per cycle: a write, or a read whose data appears next cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// File: src/clipped_frame_store_fill_engine_top.sv
// ----------------------------------------------------------------------------
// clipped_frame_store_fill_engine_top
// Small 2D drawing engine: clipped rectangle fill, single pixel blit, pixel
// read and screen clear over a local frame store held in one RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                     Beat taken when
//  -------   -----------------------------------------   -------------------
//  command   start, busy, operation_i, x_i, y_i,         start && !busy
//            width_i, height_i, color_i
//  result    done_o, pixel_value_o, hit_o                done_o (one cycle)
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,      cfg_valid_i &&
//            cfg_data_i                                  cfg_ready_o
//
//  After reset the engine sweeps the frame store to zero, one pixel per cycle,
//  over all 2**(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT)) pixels (16384 by default);
//  busy stays high during the sweep. Configuration writes are taken at any time.
//  A command whose clipped area is empty returns its result straight from the
//  bounds step, a read after the read and response states, and a fill, blit or
//  clear after its pixel walk, in which the single RAM port writes one pixel
//  per cycle. The result is held for one cycle and cannot be stalled.
//
module clipped_frame_store_fill_engine_top #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [cfse_pkg::OpW-1:0]            operation_i,
  input  logic signed [cfse_pkg::FieldW-1:0]  x_i,
  input  logic signed [cfse_pkg::FieldW-1:0]  y_i,
  input  logic signed [cfse_pkg::FieldW-1:0]  width_i,
  input  logic signed [cfse_pkg::FieldW-1:0]  height_i,
  input  logic [cfse_pkg::PixelW-1:0]         color_i,
  // Result channel
  output logic                                done_o,
  output logic [cfse_pkg::PixelW-1:0]         pixel_value_o,
  output logic                                hit_o,
  // Configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cfse_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cfse_pkg::CfgW-1:0]           cfg_data_i
);

  import cfse_pkg::*;

  // Store geometry: pixel (x, y) lives at address {y, x}.
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  // Bounds math is done in 18 bits signed, wide enough for x + width.
  localparam int unsigned SW    = FieldW + 2;

  localparam logic [CfgW-1:0] MaxWClamp = (MAX_WIDTH > 255) ? 8'd255 : 8'(MAX_WIDTH);
  localparam logic [CfgW-1:0] MaxHClamp = (MAX_HEIGHT > 255) ? 8'd255 : 8'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CfgW-1:0] scr_w_q, scr_h_q, clip_l_q, clip_t_q, clip_r_q, clip_b_q;

  // Command and walk registers.
  op_e                      op_q, op_d;
  logic signed [FieldW-1:0] x_q, x_d, y_q, y_d, w_q, w_d, h_q, h_d;
  logic [PixelW-1:0]        color_q, color_d;
  logic [CfgW-1:0]          x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [CfgW-1:0]          col_q, col_d, row_q, row_d;
  logic [AW-1:0]            clr_addr_q, clr_addr_d;

  // Result registers.
  logic              done_q, done_d, hit_q, hit_d;
  logic [PixelW-1:0] pix_q, pix_d;

  // RAM port.
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PixelW-1:0] ram_wdata, ram_rdata;

  // Clipping datapath.
  logic [CfgW-1:0]          vis_w, vis_h;
  logic                     use_clip;
  logic signed [FieldW-1:0] ext_w, ext_h;
  logic signed [SW-1:0]     xs, ys, xe, ye;
  logic signed [SW-1:0]     x0c, x1c, y0c, y1c;
  logic                     area_nonempty;

  function automatic logic signed [SW-1:0] smax(logic signed [SW-1:0] a,
                                                logic signed [SW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] smin(logic signed [SW-1:0] a,
                                                logic signed [SW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] uext(logic [CfgW-1:0] v);
    return $signed({{(SW-CfgW){1'b0}}, v});
  endfunction

  // Configuration register file; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= 8'd128;
      scr_h_q  <= 8'd128;
      clip_l_q <= 8'd0;
      clip_t_q <= 8'd0;
      clip_r_q <= 8'd128;
      clip_b_q <= 8'd128;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCREEN_W: scr_w_q  <= cfg_data_i;
        CFG_SCREEN_H: scr_h_q  <= cfg_data_i;
        CFG_CLIP_L:   clip_l_q <= cfg_data_i;
        CFG_CLIP_T:   clip_t_q <= cfg_data_i;
        CFG_CLIP_R:   clip_r_q <= cfg_data_i;
        CFG_CLIP_B:   clip_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Visible screen, limited to the store size.
  assign vis_w = (32'(scr_w_q) > MAX_WIDTH)  ? MaxWClamp : scr_w_q;
  assign vis_h = (32'(scr_h_q) > MAX_HEIGHT) ? MaxHClamp : scr_h_q;

  // Clipped bounds. A blit or read is a one by one rectangle; reads ignore
  // the clip box, and a clear covers the whole visible screen.
  always_comb begin
    use_clip = (op_q == OP_FILL) || (op_q == OP_BLIT);
    ext_w    = (op_q == OP_FILL) ? w_q : 16'sd1;
    ext_h    = (op_q == OP_FILL) ? h_q : 16'sd1;
    xs       = {{2{x_q[FieldW-1]}}, x_q};
    ys       = {{2{y_q[FieldW-1]}}, y_q};
    xe       = xs + {{2{ext_w[FieldW-1]}}, ext_w};
    ye       = ys + {{2{ext_h[FieldW-1]}}, ext_h};
    if (op_q == OP_CLEAR) begin
      x0c = '0;
      y0c = '0;
      x1c = uext(vis_w);
      y1c = uext(vis_h);
    end else begin
      x0c = smax(xs, '0);
      y0c = smax(ys, '0);
      x1c = smin(xe, uext(vis_w));
      y1c = smin(ye, uext(vis_h));
      if (use_clip) begin
        x0c = smax(x0c, uext(clip_l_q));
        y0c = smax(y0c, uext(clip_t_q));
        x1c = smin(x1c, uext(clip_r_q));
        y1c = smin(y1c, uext(clip_b_q));
      end
    end
    area_nonempty = (x1c > x0c) && (y1c > y0c);
  end

  // Sequencer: reset sweep, command capture, bounds, pixel walk, read.
  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    hit_d      = hit_q;
    pix_d      = pix_q;
    clr_addr_d = clr_addr_q;
    op_d       = op_q;
    x_d        = x_q;
    y_d        = y_q;
    w_d        = w_q;
    h_d        = h_q;
    color_d    = color_q;
    x0_d       = x0_q;
    x1_d       = x1_q;
    y0_d       = y0_q;
    y1_d       = y1_q;
    col_d      = col_q;
    row_d      = row_q;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = {YW'(row_q), XW'(col_q)};
    ram_wdata  = color_q;
    case (state_q)
      ST_CLEAR: begin
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        ram_addr   = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_d    = op_e'(operation_i);
          x_d     = x_i;
          y_d     = y_i;
          w_d     = width_i;
          h_d     = height_i;
          color_d = color_i;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        // Non-empty bounds lie in 0..255, so the low bits carry them.
        x0_d  = x0c[CfgW-1:0];
        x1_d  = x1c[CfgW-1:0];
        y0_d  = y0c[CfgW-1:0];
        y1_d  = y1c[CfgW-1:0];
        col_d = x0c[CfgW-1:0];
        row_d = y0c[CfgW-1:0];
        if (!area_nonempty) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          pix_d   = '0;
          state_d = ST_IDLE;
        end else if (op_q == OP_READ) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (col_q + 8'd1 == x1_q) begin
          col_d = x0_q;
          if (row_q + 8'd1 == y1_q) begin
            done_d  = 1'b1;
            hit_d   = 1'b1;
            pix_d   = '0;
            state_d = ST_IDLE;
          end else begin
            row_d = row_q + 8'd1;
          end
        end else begin
          col_d = col_q + 8'd1;
        end
      end
      ST_READ: begin
        ram_en  = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        done_d  = 1'b1;
        hit_d   = 1'b1;
        pix_d   = ram_rdata;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      pix_q      <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      done_q     <= done_d;
      hit_q      <= hit_d;
      pix_q      <= pix_d;
    end
  end

  // Command payload and walk position.
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    x_q     <= x_d;
    y_q     <= y_d;
    w_q     <= w_d;
    h_q     <= h_d;
    color_q <= color_d;
    x0_q    <= x0_d;
    x1_q    <= x1_d;
    y0_q    <= y0_d;
    y1_q    <= y1_d;
    col_q   <= col_d;
    row_q   <= row_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign pixel_value_o = pix_q;

  // Frame store.
  cfse_ram #(
    .WIDTH (PixelW),
    .DEPTH (Depth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // A taken command always moves on to the bounds step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_CALC))
    else $error("command taken but bounds step not entered");

  // Results are never back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // The pixel walk stays inside the clipped rectangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (col_q >= x0_q && col_q < x1_q &&
                              row_q >= y0_q && row_q < y1_q))
    else $error("fill walk left its rectangle");

  // Every written pixel lies on the visible screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (col_q < vis_w && row_q < vis_h))
    else $error("fill wrote outside the screen");

  // A non-zero pixel value is only reported for a read that hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pixel_value_o != '0) |-> hit_o)
    else $error("pixel value reported without a hit");

endmodule
